// ===== design/svd_pkg.sv =====
package svd_pkg;

  // field widths
  localparam int WAVE_W = 16;
  localparam int DATA_W = 32;
  localparam int INV_W  = 32;
  localparam int GAIN_W = 16;

  // squares and sums
  localparam int SQ_W   = 31;               // kx^2 <= 2^30
  localparam int K2_W   = 32;               // sum of three squares, unsigned Q16.16
  localparam int PROD_W = SQ_W + INV_W;     // square times reciprocal
  localparam int R2_W   = 64;               // r^2, unsigned Q16.48
  localparam int EG_W   = GAIN_W + K2_W;    // eps * k^2

  // filter table geometry
  localparam int TABLE_ADDR_BITS = 10;
  localparam int RADIUS_SQ_LIMIT = 4;
  localparam int ROM_SIZE   = 1 << TABLE_ADDR_BITS;
  // entries whose left edge lies below r^2 = 1; all later entries are exactly one
  localparam int ROM_LIVE   = (ROM_SIZE + RADIUS_SQ_LIMIT - 1) / RADIUS_SQ_LIMIT;
  localparam int ROM_IDX_W  = (ROM_LIVE > 1) ? $clog2(ROM_LIVE) : 1;
  localparam int LIVE_SPAN  = ROM_LIVE * RADIUS_SQ_LIMIT;
  localparam int SPAN_W     = $clog2(LIVE_SPAN);
  localparam int R2_SHIFT   = 48 - TABLE_ADDR_BITS;
  localparam int V_W        = R2_W - R2_SHIFT;

  // exact division by RADIUS_SQ_LIMIT for values below 2^SPAN_W
  localparam int DIV_LOG    = $clog2(RADIUS_SQ_LIMIT);
  localparam int DIV_SHIFT  = SPAN_W + DIV_LOG;
  localparam int DIV_MULT_W = SPAN_W + 1;
  localparam int DIV_MULT   = ((1 << DIV_SHIFT) + RADIUS_SQ_LIMIT - 1) / RADIUS_SQ_LIMIT;
  localparam int DIV_PROD_W = SPAN_W + DIV_MULT_W;

  // filter word, unsigned Q1.16
  localparam int FILT_W = 17;
  localparam logic [FILT_W-1:0] FILT_ONE = 17'h1_0000;

  localparam int G_LSB = 32;
  localparam int DAMP_LSB = 16;
  localparam int RES_W = DATA_W + 17;

  localparam logic [DATA_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] SAT_MIN = 32'h8000_0000;

  localparam logic [63:0] EXP_M1_Q32 = 64'd1580030169;
  localparam logic [63:0] ONE_Q32    = 64'h1_0000_0000;

  localparam logic [INV_W-1:0]  INV_RESET  = 32'd4194304;
  localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd655;

  typedef enum logic [1:0] {
    CFG_INV_KX = 2'd0,
    CFG_INV_KY = 2'd1,
    CFG_INV_KZ = 2'd2,
    CFG_GAIN   = 2'd3
  } cfg_reg_e;

  typedef logic [FILT_W-1:0] filt_t;
  typedef filt_t filt_table_t [ROM_LIVE];

  typedef struct packed {
    logic [INV_W-1:0]  inv_x;
    logic [INV_W-1:0]  inv_y;
    logic [INV_W-1:0]  inv_z;
    logic [GAIN_W-1:0] gain;
  } cfg_t;

  typedef struct packed {
    logic [DATA_W-1:0] in_real;
    logic [DATA_W-1:0] in_imag;
    logic [DATA_W-1:0] acc_real;
    logic [DATA_W-1:0] acc_imag;
  } cplx_t;

  typedef struct packed {
    logic [WAVE_W-1:0] wave_x;
    logic [WAVE_W-1:0] wave_y;
    logic [WAVE_W-1:0] wave_z;
    cplx_t             c;
  } item_t;

  typedef struct packed {
    logic [EG_W-1:0]   eg;
    logic [SPAN_W-1:0] span;
    logic              over;
    cplx_t             c;
  } radius_t;

  typedef struct packed {
    logic [EG_W-1:0] eg;
    filt_t           filt;
    cplx_t           c;
  } gain_t;

  typedef struct packed {
    logic [DATA_W-1:0] sum_real;
    logic [DATA_W-1:0] sum_imag;
  } result_t;

  // elaboration-time helpers for the filter table
  function automatic logic [63:0] isqrt64(logic [63:0] v);
    logic [63:0] rem;
    logic [63:0] res;
    logic [63:0] bw;
    rem = v;
    res = '0;
    bw  = 64'h4000_0000_0000_0000;
    for (int j = 0; j < 32; j++) begin
      if (rem >= res + bw) begin
        rem = rem - (res + bw);
        res = (res >> 1) + bw;
      end else begin
        res = res >> 1;
      end
      bw = bw >> 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] mulq32(logic [63:0] a, logic [63:0] b);
    logic [63:0] m;
    m = a * b;
    return m >> 32;
  endfunction

  function automatic logic [63:0] div_small(logic [63:0] a, int unsigned k);
    logic [63:0] q;
    case (k)
      1:  q = a;
      2:  q = a / 64'd2;
      3:  q = a / 64'd3;
      4:  q = a / 64'd4;
      5:  q = a / 64'd5;
      6:  q = a / 64'd6;
      7:  q = a / 64'd7;
      8:  q = a / 64'd8;
      9:  q = a / 64'd9;
      10: q = a / 64'd10;
      11: q = a / 64'd11;
      12: q = a / 64'd12;
      13: q = a / 64'd13;
      14: q = a / 64'd14;
      15: q = a / 64'd15;
      16: q = a / 64'd16;
      default: q = a;
    endcase
    return q;
  endfunction

  // 1 - exp(-36 * x^3.75) at the left edge x = r^2 of entry i, rounded to Q1.16
  function automatic filt_t filt_entry(int unsigned i);
    logic [63:0] x;
    logic [63:0] s;
    logic [63:0] q;
    logic [63:0] p;
    logic [63:0] t;
    logic [63:0] f;
    logic [63:0] term;
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] e;
    logic [63:0] val;
    logic [31:0] n;
    x = 64'(i * RADIUS_SQ_LIMIT) << (32 - TABLE_ADDR_BITS);
    s = isqrt64(x << 32);
    q = isqrt64(s << 32);
    p = mulq32(mulq32(mulq32(x, x), x), mulq32(s, q));
    t = 64'd36 * p;
    n = t[63:32];
    f = {32'd0, t[31:0]};
    term = ONE_Q32;
    pos  = ONE_Q32;
    neg  = '0;
    for (int unsigned k = 1; k <= 16; k++) begin
      term = div_small(mulq32(term, f), k);
      if ((k & 1) != 0) neg = neg + term;
      else              pos = pos + term;
    end
    e = (pos > neg) ? pos - neg : 64'd0;
    for (int unsigned j = 0; j < 64; j++) begin
      if (j < n) e = mulq32(e, EXP_M1_Q32);
    end
    if (e > ONE_Q32) e = ONE_Q32;
    val = (ONE_Q32 - e + 64'd32768) >> 16;
    return val[FILT_W-1:0];
  endfunction

  function automatic filt_table_t build_filt_table();
    filt_table_t tab;
    for (int unsigned i = 0; i < ROM_LIVE; i++) begin
      tab[i] = filt_entry(i);
    end
    return tab;
  endfunction

  localparam filt_table_t FILT_TABLE = build_filt_table();

endpackage

// ===== design/svd_radius.sv =====
module svd_radius import svd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_t    cfg_i,
  input  logic    valid_i,
  input  item_t   item_i,
  output logic    ready_o,
  output logic    valid_o,
  output radius_t radius_o,
  input  logic    ready_i
);

  // stage 1: squares
  logic            v1_q;
  logic [SQ_W-1:0] sqx_q, sqy_q, sqz_q;
  cplx_t           c1_q;
  // stage 2: k^2 and per-axis products
  logic              v2_q;
  logic [K2_W-1:0]   k2_q;
  logic [PROD_W-1:0] px_q, py_q, pz_q;
  cplx_t             c2_q;
  // stage 3: r^2 window and eps * k^2
  logic    v3_q;
  radius_t r3_q;

  logic rdy1, rdy2, rdy3;

  logic signed [2*WAVE_W-1:0] sqx_d, sqy_d, sqz_d;
  logic [K2_W-1:0]            k2_d;
  logic [PROD_W-1:0]          px_d, py_d, pz_d;
  logic [R2_W-1:0]            r2_d;
  logic [V_W-1:0]             vfull_d;
  radius_t                    r3_d;

  assign rdy3    = !v3_q || ready_i;
  assign rdy2    = !v2_q || rdy3;
  assign rdy1    = !v1_q || rdy2;
  assign ready_o = rdy1;

  always_comb begin
    sqx_d = $signed(item_i.wave_x) * $signed(item_i.wave_x);
    sqy_d = $signed(item_i.wave_y) * $signed(item_i.wave_y);
    sqz_d = $signed(item_i.wave_z) * $signed(item_i.wave_z);
  end

  always_comb begin
    k2_d = K2_W'(sqx_q) + K2_W'(sqy_q) + K2_W'(sqz_q);
    px_d = PROD_W'(sqx_q) * PROD_W'(cfg_i.inv_x);
    py_d = PROD_W'(sqy_q) * PROD_W'(cfg_i.inv_y);
    pz_d = PROD_W'(sqz_q) * PROD_W'(cfg_i.inv_z);
  end

  always_comb begin
    r2_d       = R2_W'(px_q) + R2_W'(py_q) + R2_W'(pz_q);
    vfull_d    = r2_d[R2_W-1:R2_SHIFT];
    r3_d.over  = (vfull_d >= V_W'(LIVE_SPAN));
    r3_d.span  = vfull_d[SPAN_W-1:0];
    r3_d.eg    = EG_W'(cfg_i.gain) * EG_W'(k2_q);
    r3_d.c     = c2_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && valid_i) begin
      sqx_q <= sqx_d[SQ_W-1:0];
      sqy_q <= sqy_d[SQ_W-1:0];
      sqz_q <= sqz_d[SQ_W-1:0];
      c1_q  <= item_i.c;
    end
    if (rdy2 && v1_q) begin
      k2_q <= k2_d;
      px_q <= px_d;
      py_q <= py_d;
      pz_q <= pz_d;
      c2_q <= c1_q;
    end
    if (rdy3 && v2_q) begin
      r3_q <= r3_d;
    end
  end

  assign valid_o  = v3_q;
  assign radius_o = r3_q;

endmodule

// ===== design/svd_filter.sv =====
module svd_filter import svd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    valid_i,
  input  radius_t radius_i,
  output logic    ready_o,
  output logic    valid_o,
  output gain_t   gain_o,
  input  logic    ready_i
);

  // stage 4: table index
  logic                 v4_q;
  logic [ROM_IDX_W-1:0] idx_q;
  logic                 over_q;
  logic [EG_W-1:0]      eg4_q;
  cplx_t                c4_q;
  // stage 5: filter value
  logic  v5_q;
  gain_t g5_q;

  logic rdy4, rdy5;

  logic [DIV_PROD_W-1:0] div_prod_d;
  gain_t                 g5_d;

  assign rdy5    = !v5_q || ready_i;
  assign rdy4    = !v4_q || rdy5;
  assign ready_o = rdy4;

  // span / RADIUS_SQ_LIMIT by reciprocal, exact below 2^SPAN_W
  assign div_prod_d = DIV_PROD_W'(radius_i.span) * DIV_PROD_W'(DIV_MULT);

  always_comb begin
    g5_d.eg   = eg4_q;
    g5_d.c    = c4_q;
    g5_d.filt = over_q ? FILT_ONE : FILT_TABLE[idx_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (rdy4) v4_q <= valid_i;
      if (rdy5) v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy4 && valid_i) begin
      idx_q  <= div_prod_d[DIV_SHIFT +: ROM_IDX_W];
      over_q <= radius_i.over;
      eg4_q  <= radius_i.eg;
      c4_q   <= radius_i.c;
    end
    if (rdy5 && v4_q) begin
      g5_q <= g5_d;
    end
  end

  assign valid_o = v5_q;
  assign gain_o  = g5_q;

endmodule

// ===== design/svd_damp.sv =====
module svd_damp import svd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    valid_i,
  input  gain_t   gain_i,
  output logic    ready_o,
  output logic    valid_o,
  output result_t result_o,
  input  logic    ready_i
);

  // stage 6: damping coefficient g
  logic              v6_q;
  logic [DATA_W-1:0] g_q;
  cplx_t             c6_q;
  // stage 7: in * g for both parts
  logic              v7_q;
  logic [63:0]       pr_q, pi_q;
  logic [DATA_W-1:0] ar7_q, ai7_q;
  // stage 8: output register
  logic    v8_q;
  result_t res_q;

  logic rdy6, rdy7, rdy8;

  logic [EG_W+FILT_W-1:0]     gp_d;
  logic signed [DATA_W*2:0]   pr_full_d, pi_full_d;
  result_t                    res_d;

  assign rdy8    = !v8_q || ready_i;
  assign rdy7    = !v7_q || rdy8;
  assign rdy6    = !v6_q || rdy7;
  assign ready_o = rdy6;

  assign gp_d = (EG_W+FILT_W)'(gain_i.eg) * (EG_W+FILT_W)'(gain_i.filt);

  always_comb begin
    pr_full_d = $signed(c6_q.in_real) * $signed({1'b0, g_q});
    pi_full_d = $signed(c6_q.in_imag) * $signed({1'b0, g_q});
  end

  // acc - floor(p / 2^16), then clamp to the signed 32 bit range
  function automatic logic [DATA_W-1:0] sat_sub(logic [DATA_W-1:0] acc, logic [63:0] p);
    logic [RES_W-1:0] r;
    logic [63-DAMP_LSB:0] d;
    d = p[63:DAMP_LSB];
    r = {{(RES_W-DATA_W){acc[DATA_W-1]}}, acc} - {d[63-DAMP_LSB], d};
    if (r[RES_W-1:DATA_W-1] == '0 || r[RES_W-1:DATA_W-1] == '1) begin
      return r[DATA_W-1:0];
    end
    return r[RES_W-1] ? SAT_MIN : SAT_MAX;
  endfunction

  always_comb begin
    res_d.sum_real = sat_sub(ar7_q, pr_q);
    res_d.sum_imag = sat_sub(ai7_q, pi_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v6_q <= 1'b0;
      v7_q <= 1'b0;
      v8_q <= 1'b0;
    end else begin
      if (rdy6) v6_q <= valid_i;
      if (rdy7) v7_q <= v6_q;
      if (rdy8) v8_q <= v7_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy6 && valid_i) begin
      g_q  <= gp_d[G_LSB +: DATA_W];
      c6_q <= gain_i.c;
    end
    if (rdy7 && v6_q) begin
      pr_q  <= pr_full_d[63:0];
      pi_q  <= pi_full_d[63:0];
      ar7_q <= c6_q.acc_real;
      ai7_q <= c6_q.acc_imag;
    end
    if (rdy8 && v7_q) begin
      res_q <= res_d;
    end
  end

  assign valid_o  = v8_q;
  assign result_o = res_q;

endmodule

// ===== design/spectral_viscosity_damping.sv =====
// channel | direction | handshake               | word
// --------+-----------+-------------------------+---------------------------------------------
// in      | input     | in_valid_i / in_stall_o | wave_x/y/z, in_real/imag, acc_real/imag
// out     | output    | out_valid_o/out_stall_i | sum_real, sum_imag
// cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// one word per cycle sustained unless out_stall_i holds the output; eight register stages
// from input to the output register, in order: squares, products, r^2 sum, table index,
// lookup, coefficient, damping products, saturating update
// reset clears all stage valid bits and loads the default register values
// a stall holds only the stages that are full; empty stages keep filling
module spectral_viscosity_damping import svd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  // input words
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [WAVE_W-1:0] wave_x_i,
  input  logic [WAVE_W-1:0] wave_y_i,
  input  logic [WAVE_W-1:0] wave_z_i,
  input  logic [DATA_W-1:0] in_real_i,
  input  logic [DATA_W-1:0] in_imag_i,
  input  logic [DATA_W-1:0] acc_real_i,
  input  logic [DATA_W-1:0] acc_imag_i,
  // result words
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [DATA_W-1:0] sum_real_o,
  output logic [DATA_W-1:0] sum_imag_o,
  // register writes
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [1:0]        cfg_index_i,
  input  logic [DATA_W-1:0] cfg_data_i
);

  cfg_t    cfg_q;
  item_t   item;
  radius_t radius;
  gain_t   gain;
  result_t result;

  logic rad_ready, rad_valid;
  logic flt_ready, flt_valid;
  logic dmp_ready, dmp_valid;

  // register file; writes are only expected while the pipeline is empty
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.inv_x <= INV_RESET;
      cfg_q.inv_y <= INV_RESET;
      cfg_q.inv_z <= INV_RESET;
      cfg_q.gain  <= GAIN_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_INV_KX: cfg_q.inv_x <= cfg_data_i;
        CFG_INV_KY: cfg_q.inv_y <= cfg_data_i;
        CFG_INV_KZ: cfg_q.inv_z <= cfg_data_i;
        CFG_GAIN:   cfg_q.gain  <= cfg_data_i[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // pack the incoming word
  assign item.wave_x     = wave_x_i;
  assign item.wave_y     = wave_y_i;
  assign item.wave_z     = wave_z_i;
  assign item.c.in_real  = in_real_i;
  assign item.c.in_imag  = in_imag_i;
  assign item.c.acc_real = acc_real_i;
  assign item.c.acc_imag = acc_imag_i;

  assign in_stall_o = !rad_ready;

  // stages 1-3: squares, k^2, r^2 window, eps * k^2
  svd_radius u_radius (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .valid_i  (in_valid_i),
    .item_i   (item),
    .ready_o  (rad_ready),
    .valid_o  (rad_valid),
    .radius_o (radius),
    .ready_i  (flt_ready)
  );

  // stages 4-5: table index and filter lookup, one beyond the table
  svd_filter u_filter (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (rad_valid),
    .radius_i (radius),
    .ready_o  (flt_ready),
    .valid_o  (flt_valid),
    .gain_o   (gain),
    .ready_i  (dmp_ready)
  );

  // stages 6-8: coefficient, damping products, saturating update
  svd_damp u_damp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (flt_valid),
    .gain_i   (gain),
    .ready_o  (dmp_ready),
    .valid_o  (dmp_valid),
    .result_o (result),
    .ready_i  (!out_stall_i)
  );

  assign out_valid_o = dmp_valid;
  assign sum_real_o  = result.sum_real;
  assign sum_imag_o  = result.sum_imag;

endmodule
